// ----- hdl/s2cd_pkg.sv -----
// Shared types and codes for the serial-to-CAN deframer.
// No dependencies; imported by s2cd_core and serial_to_can_deframer_unit.
package s2cd_pkg;

  // Parser phases.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_IDLO = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam logic [7:0] SYNC_RESET = 8'h24;

  // One emitted CAN frame.
  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

endpackage

// ----- hdl/serial_to_can_deframer_unit.sv -----
// Serial-to-CAN deframer top level: input beat register, parser, result register.
// Depends on s2cd_pkg and s2cd_core.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | in_valid / in_ready    | rx_byte[7:0], burst_end
//   output   | out_valid / out_ready  | frame_id[10:0], frame_len[3:0],
//            |                        | frame_data[63:0]
//   config   | cfg_wr_en              | cfg_wr_data[7:0] (sync byte)
//
// One byte per cycle sustained while the output is not stalled; the byte that
// completes a frame passes the input register, then the result register.
// Reset is synchronous and returns the parser to hunting with sync byte 0x24.
// A stalled output holds its frame; the input register keeps accepting until
// a byte is waiting behind the stalled frame.
module serial_to_can_deframer_unit #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        burst_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] frame_id,
  output logic [3:0]  frame_len,
  output logic [63:0] frame_data,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import s2cd_pkg::*;

  logic [7:0] sync_reg;
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;
  logic       step;
  logic       emit;
  frame_t     frame;

  // Sync byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_reg <= cfg_wr_data;
    end
  end

  // The parser takes the held beat when the result register can take a frame.
  assign step     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  // Input beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
      in_q_last <= burst_end;
    end
  end

  s2cd_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_q_byte),
    .burst_end(in_q_last),
    .sync_byte(sync_reg),
    .emit     (emit),
    .frame    (frame)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      frame_id   <= frame.id;
      frame_len  <= frame.len;
      frame_data <= frame.data;
    end
  end

  // A frame waiting on a stalled output is never overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !step)
    else $error("parser advanced while a frame was stalled");

  // Emitted frames carry between one and MAX_PAYLOAD bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_len != 4'd0 && frame_len <= 4'(MAX_PAYLOAD)))
    else $error("frame length out of range");

  // A beat held in the input register that is not consumed blocks new input.
  assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !step) |-> !in_ready)
    else $error("input register would be overwritten");

  // A frame closed by the parser is presented on the output at the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> out_valid)
    else $error("emitted frame lost");

endmodule

// ----- hdl/s2cd_core.sv -----
// Per-byte parser of the deframer: message state and frame assembly.
// Depends on s2cd_pkg for phase codes and the frame_t type.
module s2cd_core #(
  parameter int MAX_PAYLOAD = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             burst_end,
  input  logic [7:0]       sync_byte,
  output logic             emit,
  output s2cd_pkg::frame_t frame
);
  import s2cd_pkg::*;

  localparam logic [3:0] MaxFill = 4'(MAX_PAYLOAD);

  logic [1:0]  phase, phase_next;
  logic [4:0]  remaining, remaining_next;
  logic [10:0] cur_id, cur_id_next;
  logic [63:0] buffer, buffer_next;
  logic [3:0]  fill, fill_next;

  logic [63:0] buf_added;
  logic [3:0]  fill_inc;
  logic [4:0]  rem_dec;

  // Next state and frame output for the byte being processed.
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    cur_id_next    = cur_id;
    buffer_next    = buffer;
    fill_next      = fill;
    emit           = 1'b0;
    buf_added      = buffer;
    buf_added[{fill[2:0], 3'b000} +: 8] = rx_byte;
    fill_inc       = fill + 4'd1;
    rem_dec        = remaining - 5'd1;
    frame.id       = cur_id;
    frame.len      = fill_inc;
    frame.data     = buf_added;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == sync_byte) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte[7:3] == 5'd0) begin
          // Zero length: the same byte may itself be a new sync byte.
          phase_next = (rx_byte == sync_byte) ? PH_LEN : PH_HUNT;
        end else begin
          remaining_next = rx_byte[7:3];
          cur_id_next    = {rx_byte[2:0], 8'h00};
          phase_next     = PH_IDLO;
        end
      end
      PH_IDLO: begin
        cur_id_next = cur_id | {3'b000, rx_byte};
        buffer_next = '0;
        fill_next   = '0;
        phase_next  = PH_DATA;
      end
      PH_DATA: begin
        remaining_next = rem_dec;
        if (rem_dec == 5'd0 || fill_inc >= MaxFill || burst_end) begin
          emit        = 1'b1;
          buffer_next = '0;
          fill_next   = '0;
          if (rem_dec == 5'd0) phase_next = PH_HUNT;
        end else begin
          buffer_next = buf_added;
          fill_next   = fill_inc;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      remaining <= '0;
      cur_id    <= '0;
      buffer    <= '0;
      fill      <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      cur_id    <= cur_id_next;
      buffer    <= buffer_next;
      fill      <= fill_next;
    end
  end

endmodule
